// File: hw/rtl/pidmc_pkg.sv
package pidmc_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned CPR_DEF     = 2249;
  localparam int unsigned TICK_MS_DEF = 50;

  // Control-law constants
  localparam int unsigned MS_PER_MIN   = 60000;
  localparam int unsigned DRIVE_MAX    = 250;
  localparam int unsigned BOOST_LEVEL  = 9;
  localparam int unsigned GATE_FACTOR  = 360;
  localparam int unsigned SETTLE_TICKS = 3;

  // Serial arithmetic widths
  localparam int MUL_AW = 33;
  localparam int MUL_BW = 48;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_TARGET = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_GAIN_P = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_GAIN_I = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_GAIN_D = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_THRESH = 3'd5;

  // Request codes
  localparam logic [1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // Control modes
  localparam logic [1:0] MODE_POS = 2'd1;
  localparam logic [1:0] MODE_SPD = 2'd2;

  // Maneuver status
  localparam logic [1:0] STAT_WAIT = 2'd0;
  localparam logic [1:0] STAT_DONE = 2'd3;

  typedef struct packed {
    logic              go;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic              go;
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic [31:0] count;
    logic        err;
  } qdec_t;

endpackage

// File: hw/rtl/pidmc_if.sv
interface pidmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       enc_a;
  logic       enc_b;

  modport source (output valid, output req_type, output enc_a, output enc_b, input ready);
  modport sink (input valid, input req_type, input enc_a, input enc_b, output ready);
endinterface

interface pidmc_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        pwm_duty;
  logic              reverse_dir;
  logic signed [8:0] drive_value;
  logic [1:0]        maneuver_status;
  logic              quad_error;

  modport source (output valid, output pwm_duty, output reverse_dir, output drive_value,
                  output maneuver_status, output quad_error, input ready);
  modport sink (input valid, input pwm_duty, input reverse_dir, input drive_value,
                input maneuver_status, input quad_error, output ready);
endinterface

// File: hw/rtl/pidmc_quad.sv
module pidmc_quad (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              smp,
  input  logic              a,
  input  logic              b,
  output pidmc_pkg::qdec_t  qd
);
  import pidmc_pkg::*;

  logic        la_r;
  logic        lb_r;
  logic [31:0] cnt_r;
  logic        err_r;
  logic        up;
  logic        dn;

  assign up = a ^ lb_r;
  assign dn = b ^ la_r;

  // Decode one pin sample: step the count, flag a double transition
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r  <= 1'b0;
      lb_r  <= 1'b0;
      cnt_r <= '0;
      err_r <= 1'b0;
    end else if (smp) begin
      la_r <= a;
      lb_r <= b;
      if (up && !dn) begin
        cnt_r <= cnt_r + 32'd1;
      end else if (!up && dn) begin
        cnt_r <= cnt_r - 32'd1;
      end
      if ((a != la_r) && (b != lb_r)) begin
        err_r <= 1'b1;
      end
    end
  end

  assign qd.count = cnt_r;
  assign qd.err   = err_r;
endmodule

// File: hw/rtl/pidmc_mul.sv
module pidmc_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  pidmc_pkg::mul_req_t req,
  output pidmc_pkg::mul_rsp_t rsp
);
  import pidmc_pkg::*;

  localparam int CW = $clog2(MUL_BW);
  localparam logic [CW-1:0] LAST = CW'(MUL_BW - 1);

  logic [MUL_AW-1:0] a_r;
  logic [MUL_AW-1:0] hi_r;
  logic [MUL_BW-1:0] lo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [MUL_AW:0]   sum;

  // Add the multiplicand when the low multiplier bit is set
  assign sum = {1'b0, hi_r} + {1'b0, (lo_r[0] ? a_r : '0)};

  // Sequence one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Shift the partial product right
  always_ff @(posedge clk) begin
    if (req.go) begin
      a_r  <= req.a;
      hi_r <= '0;
      lo_r <= req.b;
    end else if (busy_r) begin
      hi_r <= sum[MUL_AW:1];
      lo_r <= {sum[0], lo_r[MUL_BW-1:1]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = {hi_r, lo_r};
endmodule

// File: hw/rtl/pidmc_div.sv
module pidmc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pidmc_pkg::div_req_t req,
  output pidmc_pkg::div_rsp_t rsp
);
  import pidmc_pkg::*;

  localparam int CW = $clog2(DIV_NW);
  localparam logic [CW-1:0] LAST = CW'(DIV_NW - 1);

  logic [DIV_DW-1:0] d_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_NW-1:0] quo_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  // Trial subtract of the divisor from the shifted remainder
  assign sh   = {rem_r, quo_r[DIV_NW-1]};
  assign diff = {1'b0, sh} - {2'b0, d_r};
  assign ge   = !diff[DIV_DW+1];

  // Sequence one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Restore or keep the remainder, shift in the quotient bit
  always_ff @(posedge clk) begin
    if (req.go) begin
      d_r   <= req.d;
      rem_r <= '0;
      quo_r <= req.n;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = quo_r;
endmodule

// File: hw/rtl/encoder_pid_motor_controller.sv
// Quadrature-encoder PID motor controller.
// in_if carries one request per item: an encoder pin sample, a control tick
// or a maneuver restart. out_if returns exactly one result item per request:
// PWM duty, direction, signed drive, maneuver status and the sticky
// quadrature error flag, all as they stand after that request.
// cfg_we/cfg_idx/cfg_wdata write the mode, target, three gains and the
// settle threshold; write them only while no item is in flight.
// Pin samples, restarts and unknown requests give their result in the cycle
// after acceptance and can follow back to back, one per cycle, while the receiver takes each result.
// A control tick runs through a bit-serial multiplier and a bit-serial
// divider; it takes longer in speed mode than in position mode with the
// integral gated off. No new item is taken until the tick finishes.
// The result sits in an output register; while the receiver stalls it is
// held and in_if.ready stays low, so nothing is lost or repeated.
// Synchronous reset clears the control state: count zero, drive zero, forward
// direction, status wait, error flag clear; the serial operand registers are not reset.
module encoder_pid_motor_controller #(
  parameter int unsigned COUNTS_PER_REV = pidmc_pkg::CPR_DEF,
  parameter int unsigned TICK_MS        = pidmc_pkg::TICK_MS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pidmc_in_if.sink                       in_if,
  pidmc_out_if.source                    out_if,
  input  logic                           cfg_we,
  input  logic [pidmc_pkg::CFG_IW-1:0]   cfg_idx,
  input  logic [pidmc_pkg::CFG_DW-1:0]   cfg_wdata
);
  import pidmc_pkg::*;

  // Sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LOAD     = 5'd1;
  localparam logic [4:0] S_MEAS_MUL = 5'd2;
  localparam logic [4:0] S_MEAS_DIV = 5'd3;
  localparam logic [4:0] S_ERR      = 5'd4;
  localparam logic [4:0] S_GATE     = 5'd5;
  localparam logic [4:0] S_INT_MUL  = 5'd6;
  localparam logic [4:0] S_INT_DIV  = 5'd7;
  localparam logic [4:0] S_DER_SUB  = 5'd8;
  localparam logic [4:0] S_DER_ABS  = 5'd9;
  localparam logic [4:0] S_DER_MUL  = 5'd10;
  localparam logic [4:0] S_DER_DIV  = 5'd11;
  localparam logic [4:0] S_P        = 5'd12;
  localparam logic [4:0] S_I        = 5'd13;
  localparam logic [4:0] S_D        = 5'd14;
  localparam logic [4:0] S_DRIVE    = 5'd15;
  localparam logic [4:0] S_CLAMP    = 5'd16;
  localparam logic [4:0] S_FIN      = 5'd17;

  // Divisors and multiplier constants
  localparam logic [DIV_DW-1:0] DIV_POS = DIV_DW'(COUNTS_PER_REV);
  localparam logic [DIV_DW-1:0] DIV_SPD = DIV_DW'(TICK_MS * COUNTS_PER_REV);
  localparam logic [DIV_DW-1:0] DIV_INT = DIV_DW'(MS_PER_MIN);
  localparam logic [DIV_DW-1:0] DIV_DER = DIV_DW'(TICK_MS);
  localparam logic [MUL_BW-1:0] MUL_MIN  = MUL_BW'(MS_PER_MIN);
  localparam logic [MUL_BW-1:0] MUL_INT  = MUL_BW'(256 * TICK_MS);
  localparam logic [MUL_BW-1:0] MUL_GATE = MUL_BW'(GATE_FACTOR);

  localparam logic signed [8:0]  DRV_MAX   = 9'(DRIVE_MAX);
  localparam logic signed [8:0]  DRV_BOOST = 9'(BOOST_LEVEL);
  localparam logic signed [31:0] TQ_MAX    = 32'(DRIVE_MAX);
  localparam logic [7:0]         SET_TICKS = 8'(SETTLE_TICKS);
  localparam logic [47:0]        I48_MAX   = {1'b0, {47{1'b1}}};
  localparam logic [47:0]        I48_MIN   = {1'b1, {47{1'b0}}};

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [47:0] mag48(input logic [47:0] v);
    return v[47] ? (~v + 48'd1) : v;
  endfunction

  // Signed 32-bit saturation of a quotient magnitude
  function automatic logic [31:0] satq(input logic [63:0] q, input logic neg);
    logic big;
    big = |q[63:31];
    if (neg) begin
      return big ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end
    return big ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  // Configuration registers
  logic [1:0]         mode_r;
  logic signed [31:0] target_r;
  logic [31:0]        gp_r;
  logic [31:0]        gi_r;
  logic [31:0]        gd_r;
  logic [30:0]        thr_r;

  // Controller state
  logic [31:0]        cnt_tick_r;
  logic signed [31:0] err_r;
  logic signed [31:0] err_prev_r;
  logic [47:0]        integ_r;
  logic [31:0]        deriv_r;
  logic signed [8:0]  drive_r;
  logic signed [8:0]  drive_prev_r;
  logic [7:0]         settle_r;
  logic [1:0]         status_r;
  logic               dir_r;

  // Tick working registers
  logic [4:0]         st_r;
  logic [31:0]        delta_r;
  logic [31:0]        meas_r;
  logic [32:0]        diff_r;
  logic [31:0]        abserr_r;
  logic [47:0]        sum_r;
  logic [47:0]        dsum_r;
  logic               neg_r;
  logic               out_valid_r;

  // Serial unit requests
  logic               mul_go_r;
  logic [MUL_AW-1:0]  mul_a_r;
  logic [MUL_BW-1:0]  mul_b_r;
  logic               div_go_r;
  logic [DIV_NW-1:0]  div_n_r;
  logic [DIV_DW-1:0]  div_d_r;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;
  qdec_t    qd;

  logic               in_fire;
  logic               out_fire;
  logic               smp;
  logic               set_out;
  logic [32:0]        err_sub;
  logic [48:0]        isum;
  logic [47:0]        tp;
  logic [47:0]        ti;
  logic signed [31:0] tq;
  logic signed [8:0]  drv_clamp;
  logic signed [8:0]  drv_sel;
  logic signed [8:0]  drv_boost;
  logic [7:0]         sc_base;
  logic               settled;
  logic [7:0]         settle_nxt;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign smp      = in_fire && (in_if.req_type == REQ_SAMPLE);
  assign set_out  = (in_fire && (in_if.req_type != REQ_TICK)) || (st_r == S_FIN);

  assign mul_req.go = mul_go_r;
  assign mul_req.a  = mul_a_r;
  assign mul_req.b  = mul_b_r;
  assign div_req.go = div_go_r;
  assign div_req.n  = div_n_r;
  assign div_req.d  = div_d_r;

  pidmc_quad u_quad (
    .clk   (clk),
    .rst_n (rst_n),
    .smp   (smp),
    .a     (in_if.enc_a),
    .b     (in_if.enc_b),
    .qd    (qd)
  );

  pidmc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  pidmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Datapath helpers for the current step
  always_comb begin
    err_sub = {target_r[31], target_r} - {meas_r[31], meas_r};
    if (neg_r) begin
      isum = {integ_r[47], integ_r} - {1'b0, div_rsp.q[47:0]};
    end else begin
      isum = {integ_r[47], integ_r} + {1'b0, div_rsp.q[47:0]};
    end
    tp = mul_rsp.p[71:24];
    ti = mul_rsp.p[79:32];
    tq = $signed(dsum_r[47:16]) + {31'd0, (dsum_r[47] && (|dsum_r[15:0]))};
    if (tq > TQ_MAX) begin
      drv_clamp = DRV_MAX;
    end else if (tq < -TQ_MAX) begin
      drv_clamp = -DRV_MAX;
    end else begin
      drv_clamp = tq[8:0];
    end
    drv_sel = ((mode_r == MODE_POS) || (mode_r == MODE_SPD)) ? drv_clamp : drive_r;
    drv_boost = drive_r;
    if (mode_r == MODE_POS) begin
      if ((drive_r > 9'sd0) && (drive_r < DRV_BOOST)) begin
        drv_boost = DRV_BOOST;
      end else if ((drive_r < 9'sd0) && (drive_r > -DRV_BOOST)) begin
        drv_boost = -DRV_BOOST;
      end
    end
    sc_base = (drv_boost != drive_prev_r) ? 8'd0 : settle_r;
    settled = (drv_boost != DRV_MAX) && (drv_boost != -DRV_MAX) &&
              (abserr_r <= {1'b0, thr_r});
    settle_nxt = sc_base;
    if (settled && (sc_base != 8'hFF)) begin
      settle_nxt = sc_base + 8'd1;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      target_r <= '0;
      gp_r     <= '0;
      gi_r     <= '0;
      gd_r     <= '0;
      thr_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE:   mode_r   <= cfg_wdata[1:0];
        CFG_TARGET: target_r <= cfg_wdata;
        CFG_GAIN_P: gp_r     <= cfg_wdata;
        CFG_GAIN_I: gi_r     <= cfg_wdata;
        CFG_GAIN_D: gd_r     <= cfg_wdata;
        CFG_THRESH: thr_r    <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (set_out) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Request handling and the control-tick sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      cnt_tick_r   <= '0;
      err_r        <= '0;
      err_prev_r   <= '0;
      integ_r      <= '0;
      deriv_r      <= '0;
      drive_r      <= '0;
      drive_prev_r <= '0;
      settle_r     <= '0;
      status_r     <= STAT_WAIT;
      dir_r        <= 1'b0;
      delta_r      <= '0;
      meas_r       <= '0;
      diff_r       <= '0;
      abserr_r     <= '0;
      sum_r        <= '0;
      dsum_r       <= '0;
      neg_r        <= 1'b0;
      mul_go_r     <= 1'b0;
      mul_a_r      <= '0;
      mul_b_r      <= '0;
      div_go_r     <= 1'b0;
      div_n_r      <= '0;
      div_d_r      <= '0;
    end else begin
      mul_go_r <= 1'b0;
      div_go_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_fire && (in_if.req_type == REQ_TICK)) begin
            cnt_tick_r <= qd.count;
            delta_r    <= qd.count - cnt_tick_r;
            st_r       <= S_LOAD;
          end else if (in_fire && (in_if.req_type == REQ_RESTART)) begin
            status_r   <= STAT_WAIT;
            err_r      <= '0;
            err_prev_r <= '0;
            deriv_r    <= '0;
            if (mode_r == MODE_POS) begin
              integ_r <= '0;
            end
            if (mode_r == MODE_SPD) begin
              drive_r <= '0;
            end
          end
        end
        S_LOAD: begin
          // Start the measurement, or go straight to the integral gate
          if (mode_r == MODE_POS) begin
            div_go_r <= 1'b1;
            div_n_r  <= {16'd0, mag32(cnt_tick_r), 16'd0};
            div_d_r  <= DIV_POS;
            neg_r    <= cnt_tick_r[31];
            st_r     <= S_MEAS_DIV;
          end else if (mode_r == MODE_SPD) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= {1'b0, mag32(delta_r)};
            mul_b_r  <= MUL_MIN;
            neg_r    <= delta_r[31];
            st_r     <= S_MEAS_MUL;
          end else begin
            mul_go_r <= 1'b1;
            mul_a_r  <= {2'b0, thr_r};
            mul_b_r  <= MUL_GATE;
            st_r     <= S_GATE;
          end
        end
        S_MEAS_MUL: begin
          if (mul_rsp.done) begin
            div_go_r <= 1'b1;
            div_n_r  <= {mul_rsp.p[47:0], 16'd0};
            div_d_r  <= DIV_SPD;
            st_r     <= S_MEAS_DIV;
          end
        end
        S_MEAS_DIV: begin
          if (div_rsp.done) begin
            meas_r <= satq(div_rsp.q, neg_r);
            st_r   <= S_ERR;
          end
        end
        S_ERR: begin
          if (err_sub[32] != err_sub[31]) begin
            err_r <= err_sub[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          end else begin
            err_r <= err_sub[31:0];
          end
          mul_go_r <= 1'b1;
          mul_a_r  <= {2'b0, thr_r};
          mul_b_r  <= MUL_GATE;
          st_r     <= S_GATE;
        end
        S_GATE: begin
          abserr_r <= mag32(err_r);
          if (mul_rsp.done) begin
            if ((mode_r != MODE_POS) || ({8'd0, abserr_r} < mul_rsp.p[39:0])) begin
              mul_go_r <= 1'b1;
              mul_a_r  <= {1'b0, abserr_r};
              mul_b_r  <= MUL_INT;
              neg_r    <= err_r[31];
              st_r     <= S_INT_MUL;
            end else begin
              st_r <= S_DER_SUB;
            end
          end
        end
        S_INT_MUL: begin
          if (mul_rsp.done) begin
            div_go_r <= 1'b1;
            div_n_r  <= mul_rsp.p[63:0];
            div_d_r  <= DIV_INT;
            st_r     <= S_INT_DIV;
          end
        end
        S_INT_DIV: begin
          // Accumulate the step, saturate to 48 bits
          if (div_rsp.done) begin
            if (isum[48] != isum[47]) begin
              integ_r <= isum[48] ? I48_MIN : I48_MAX;
            end else begin
              integ_r <= isum[47:0];
            end
            st_r <= S_DER_SUB;
          end
        end
        S_DER_SUB: begin
          diff_r <= {err_r[31], err_r} - {err_prev_r[31], err_prev_r};
          st_r   <= S_DER_ABS;
        end
        S_DER_ABS: begin
          mul_go_r <= 1'b1;
          mul_a_r  <= mag33(diff_r);
          mul_b_r  <= MUL_MIN;
          neg_r    <= diff_r[32];
          st_r     <= S_DER_MUL;
        end
        S_DER_MUL: begin
          if (mul_rsp.done) begin
            div_go_r <= 1'b1;
            div_n_r  <= mul_rsp.p[63:0];
            div_d_r  <= DIV_DER;
            st_r     <= S_DER_DIV;
          end
        end
        S_DER_DIV: begin
          if (div_rsp.done) begin
            deriv_r  <= satq(div_rsp.q, neg_r);
            mul_go_r <= 1'b1;
            mul_a_r  <= {1'b0, mag32(gp_r)};
            mul_b_r  <= {16'd0, mag32(err_r)};
            neg_r    <= gp_r[31] ^ err_r[31];
            st_r     <= S_P;
          end
        end
        S_P: begin
          if (mul_rsp.done) begin
            sum_r    <= neg_r ? (~tp + 48'd1) : tp;
            mul_go_r <= 1'b1;
            mul_a_r  <= {1'b0, mag32(gi_r)};
            mul_b_r  <= mag48(integ_r);
            neg_r    <= gi_r[31] ^ integ_r[47];
            st_r     <= S_I;
          end
        end
        S_I: begin
          if (mul_rsp.done) begin
            sum_r    <= neg_r ? (sum_r - ti) : (sum_r + ti);
            mul_go_r <= 1'b1;
            mul_a_r  <= {1'b0, mag32(gd_r)};
            mul_b_r  <= {16'd0, mag32(deriv_r)};
            neg_r    <= gd_r[31] ^ deriv_r[31];
            st_r     <= S_D;
          end
        end
        S_D: begin
          if (mul_rsp.done) begin
            sum_r <= neg_r ? (sum_r - tp) : (sum_r + tp);
            st_r  <= S_DRIVE;
          end
        end
        S_DRIVE: begin
          // Speed mode adds the PID sum to the present drive
          if (mode_r == MODE_SPD) begin
            dsum_r <= sum_r + {{23{drive_r[8]}}, drive_r, 16'd0};
          end else begin
            dsum_r <= sum_r;
          end
          st_r <= S_CLAMP;
        end
        S_CLAMP: begin
          drive_r <= drv_sel;
          if (drv_sel > 9'sd0) begin
            dir_r <= 1'b0;
          end else if (drv_sel < 9'sd0) begin
            dir_r <= 1'b1;
          end
          st_r <= S_FIN;
        end
        S_FIN: begin
          // Boost small drives in position mode, update the settling count
          drive_r      <= drv_boost;
          drive_prev_r <= drv_boost;
          err_prev_r   <= err_r;
          settle_r     <= settle_nxt;
          if (settled && (settle_nxt >= SET_TICKS)) begin
            status_r <= STAT_DONE;
          end
          st_r <= S_IDLE;
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready = (st_r == S_IDLE) && (!out_valid_r || out_if.ready);

  assign out_if.valid           = out_valid_r;
  assign out_if.pwm_duty        = drive_r[8] ? 8'(-drive_r) : drive_r[7:0];
  assign out_if.reverse_dir     = dir_r;
  assign out_if.drive_value     = drive_r;
  assign out_if.maneuver_status = status_r;
  assign out_if.quad_error      = qd.err;
endmodule

// File: hw/rtl/pidmc_chk.sv
module pidmc_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [7:0]        pwm_duty,
  input logic              reverse_dir,
  input logic signed [8:0] drive_value,
  input logic              quad_error
);
  logic in_fire;
  logic out_fire;
  logic pend_r;
  logic qseen_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Track the outstanding item and the sticky error seen so far
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      qseen_r <= 1'b0;
    end else begin
      pend_r <= (pend_r && !out_fire) || in_fire;
      if (out_fire && quad_error) begin
        qseen_r <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_owed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r)
    else $error("result without an accepted item");

  a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!pend_r || out_fire))
    else $error("item accepted while a result is still owed");

  a_drive_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pwm_duty == (drive_value[8] ? 8'(-drive_value) : drive_value[7:0])) &&
                  ((drive_value == 9'sd0) || (reverse_dir == drive_value[8])))
    else $error("duty or direction disagrees with drive");

  a_qerr_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && qseen_r |-> quad_error)
    else $error("quadrature error flag cleared");
endmodule

bind encoder_pid_motor_controller pidmc_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .pwm_duty    (out_if.pwm_duty),
  .reverse_dir (out_if.reverse_dir),
  .drive_value (out_if.drive_value),
  .quad_error  (out_if.quad_error)
);
